// ----- rtl/dsm_pkg.sv -----
`timescale 1ns / 1ps

package dsm_pkg;

    localparam int SLOT_W = 2;
    localparam int CW_W   = 32;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic [1:0] KIND_EXEC   = 2'd0;
    localparam logic [1:0] KIND_WRITE  = 2'd1;
    localparam logic [1:0] KIND_READ   = 2'd2;
    localparam logic [1:0] KIND_ACCESS = 2'd3;

    localparam logic [1:0] RW_EXECUTE = 2'd0;
    localparam logic [1:0] RW_WRITE   = 2'd1;
    localparam logic [1:0] RW_ACCESS  = 2'd3;

    localparam logic [1:0] REG_ALLOW_EIGHT_BYTE = 2'd0;

    localparam logic [CW_W-1:0] SLOT0_EXTRA = 32'h0000_0302;

    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  kind;
        logic [63:0] addr;
        logic [3:0]  length;
        logic [3:0]  status_bits;
    } req_t;

    typedef struct packed {
        logic            ok;
        logic [1:0]      slot;
        logic [63:0]     hit_addr;
        logic [1:0]      hit_kind;
        logic [CW_W-1:0] control_word;
    } rsp_t;

    typedef struct packed {
        logic       hit;
        logic       ok;
        logic [1:0] rw;
    } scan_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESP
    } state_t;

endpackage

// ----- rtl/dsm_slot_unit.sv -----
`timescale 1ns / 1ps

module dsm_slot_unit #(
    parameter int ADDR_WIDTH = 64
) (
    input  logic [dsm_pkg::CW_W-1:0]   cw,
    input  logic [ADDR_WIDTH-1:0]      slot_addr,
    input  logic [ADDR_WIDTH-1:0]      req_addr,
    input  logic [1:0]                 op,
    input  logic [1:0]                 kind,
    input  logic [1:0]                 len_code,
    input  logic                       flagged,
    input  logic [dsm_pkg::SLOT_W-1:0] idx,
    output dsm_pkg::scan_t             scan,
    output logic [dsm_pkg::CW_W-1:0]   cw_next
);

    logic [4:0]              en_sh;
    logic [4:0]              fld_sh;
    logic [1:0]              en;
    logic [1:0]              rw;
    logic                    addr_eq;
    logic [dsm_pkg::CW_W-1:0] add_cw;
    logic [dsm_pkg::CW_W-1:0] rem_cw;

    assign en_sh   = {2'b00, idx, 1'b0};
    assign fld_sh  = {1'b1, idx, 2'b00};
    assign en      = cw[en_sh +: 2];
    assign rw      = cw[fld_sh +: 2];
    assign addr_eq = (slot_addr == req_addr);

    always_comb
    begin
        add_cw = (cw & ~(32'hF << fld_sh)) | ({28'd0, len_code, kind} << fld_sh)
                 | (32'h1 << en_sh);
        if (idx == '0)
        begin
            add_cw = add_cw | dsm_pkg::SLOT0_EXTRA;
        end
        rem_cw = cw & ~(32'h3 << en_sh);
    end

    always_comb
    begin
        scan.hit = 1'b0;
        scan.ok  = 1'b0;
        scan.rw  = rw;
        cw_next  = cw;
        case (op)
            dsm_pkg::OP_ADD:
            begin
                scan.hit = (en == 2'b00);
                scan.ok  = 1'b1;
                cw_next  = add_cw;
            end
            dsm_pkg::OP_REMOVE:
            begin
                scan.hit = addr_eq &&
                           ((rw == dsm_pkg::RW_EXECUTE) == (kind == dsm_pkg::KIND_EXEC));
                scan.ok  = 1'b1;
                cw_next  = rem_cw;
            end
            dsm_pkg::OP_QUERY:
            begin
                scan.hit = flagged && (en != 2'b00);
                if (kind == dsm_pkg::KIND_EXEC)
                begin
                    scan.ok = addr_eq && (rw == dsm_pkg::RW_EXECUTE);
                end
                else
                begin
                    scan.ok = (rw == dsm_pkg::RW_WRITE) || (rw == dsm_pkg::RW_ACCESS);
                end
            end
            default:
            begin
                scan.hit = 1'b0;
            end
        endcase
    end

endmodule

// ----- rtl/debug_slot_manager.sv -----
`timescale 1ns / 1ps
// Each request beat gets one response beat; rejected and unused requests
// skip the scan, which checks one slot per cycle through a single shared
// compare unit.
// One request in flight: the next is taken only after the response beat.
// Reset: control word and slot addresses clear, allow_eight_byte set to 1.

module debug_slot_manager #(
    parameter int NUM_SLOTS  = 4,
    parameter int ADDR_WIDTH = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  dsm_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output dsm_pkg::rsp_t rsp,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [1:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    dsm_pkg::state_t           state_reg, state_next;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    dsm_pkg::req_t             req_reg, req_next;
    dsm_pkg::rsp_t             rsp_reg, rsp_next;
    logic [dsm_pkg::CW_W-1:0]  cw_reg, cw_next;
    logic [ADDR_WIDTH-1:0]     slot_addr_reg [NUM_SLOTS];
    logic                      allow_reg;

    logic                      slot_we;
    logic [ADDR_WIDTH-1:0]     slot_wdata;
    logic [ADDR_WIDTH-1:0]     req_addr;
    logic                      size_ok;
    logic                      pass;
    dsm_pkg::scan_t            scan;
    logic [dsm_pkg::CW_W-1:0]  unit_cw;
    logic [1:0]                len_code;

    assign pready    = 1'b1;
    assign prdata    = {31'd0, allow_reg};
    assign req_ready = (state_reg == dsm_pkg::ST_IDLE);
    assign rsp_valid = (state_reg == dsm_pkg::ST_RESP);
    assign rsp       = rsp_reg;
    assign req_addr  = req_reg.addr[ADDR_WIDTH-1:0];
    assign len_code  = req_reg.length[1:0] - 2'd1;

    always_comb
    begin
        case (req.length)
            4'd1:    size_ok = 1'b1;
            4'd2:    size_ok = (req.addr[0] == 1'b0);
            4'd4:    size_ok = (req.addr[1:0] == 2'b00);
            4'd8:    size_ok = allow_reg && (req.addr[2:0] == 3'b000);
            default: size_ok = 1'b0;
        endcase
        case (req.op)
            dsm_pkg::OP_ADD,
            dsm_pkg::OP_REMOVE: pass = (req.kind != dsm_pkg::KIND_READ) && size_ok;
            dsm_pkg::OP_QUERY:  pass = 1'b1;
            default:            pass = 1'b0;
        endcase
    end

    dsm_slot_unit #(
        .ADDR_WIDTH(ADDR_WIDTH)
    ) u_unit (
        .cw       (cw_reg),
        .slot_addr(slot_addr_reg[idx_reg]),
        .req_addr (req_addr),
        .op       (req_reg.op),
        .kind     (req_reg.kind),
        .len_code (len_code),
        .flagged  (req_reg.status_bits[idx_reg]),
        .idx      (dsm_pkg::SLOT_W'(idx_reg)),
        .scan     (scan),
        .cw_next  (unit_cw)
    );

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        req_next   = req_reg;
        rsp_next   = rsp_reg;
        cw_next    = cw_reg;
        slot_we    = 1'b0;
        slot_wdata = '0;
        case (state_reg)
            dsm_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_next = req;
                    idx_next = '0;
                    rsp_next = '0;
                    rsp_next.control_word = cw_reg;
                    state_next = pass ? dsm_pkg::ST_SCAN : dsm_pkg::ST_RESP;
                end
            end
            dsm_pkg::ST_SCAN:
            begin
                if (scan.hit)
                begin
                    rsp_next.ok   = scan.ok;
                    rsp_next.slot = dsm_pkg::SLOT_W'(idx_reg);
                    if (req_reg.op == dsm_pkg::OP_QUERY)
                    begin
                        rsp_next.hit_kind = scan.rw;
                        if (req_reg.kind != dsm_pkg::KIND_EXEC)
                        begin
                            rsp_next.hit_addr = 64'(slot_addr_reg[idx_reg]);
                        end
                    end
                    else
                    begin
                        slot_we    = 1'b1;
                        slot_wdata = (req_reg.op == dsm_pkg::OP_ADD) ? req_addr : '0;
                        cw_next    = unit_cw;
                    end
                    rsp_next.control_word = unit_cw;
                    state_next = dsm_pkg::ST_RESP;
                end
                else if (idx_reg == IDX_W'(NUM_SLOTS - 1))
                begin
                    state_next = dsm_pkg::ST_RESP;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            dsm_pkg::ST_RESP:
            begin
                if (rsp_ready)
                begin
                    state_next = dsm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dsm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dsm_pkg::ST_IDLE;
            idx_reg   <= '0;
            cw_reg    <= '0;
            allow_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            cw_reg    <= cw_next;
            if (psel && penable && pwrite && paddr == dsm_pkg::REG_ALLOW_EIGHT_BYTE)
            begin
                allow_reg <= pwdata[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        rsp_reg <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                slot_addr_reg[i] <= '0;
            end
        end
        else if (slot_we)
        begin
            slot_addr_reg[idx_reg] <= slot_wdata;
        end
    end

endmodule

// ----- rtl/dsm_checker.sv -----
`timescale 1ns / 1ps

module dsm_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input dsm_pkg::rsp_t rsp
);

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        !(req_ready && rsp_valid))
        else $error("request taken while a response is pending");

    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("ready stayed high after a request beat");

    a_rsp_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_ready) |=> !rsp_valid)
        else $error("response repeated after its beat");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)))
        else $error("response dropped or changed while stalled");

endmodule

bind debug_slot_manager dsm_checker u_dsm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
);
